// ===== hw/rtl/pal_pkg.sv =====
// Package for the positional array list unit.
// Shared constants, field widths and operation codes; no dependencies.
package pal_pkg;

   localparam int DEPTH_DEF      = 64;
   localparam int WORD_WIDTH_DEF = 32;

   localparam int OP_W    = 2;
   localparam int POS_W   = 6;
   localparam int VALUE_W = 32;
   localparam int CAP_W   = 7;
   localparam int LEN_W   = 7;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_GET    = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

endpackage

// ===== hw/rtl/pal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used as the entry store of the positional array list unit.
module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/positional_array_list_unit.sv =====
// Positional array list: ordered word list with insert, get, delete and clear.
// Depends on pal_pkg and on pal_ram for the entry store.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tuser op, tdata position/value
//  rsp     | out       | rsp_tvalid/rsp_tready  | tuser ok, tdata read_value/length
//  csr     | in        | csr_valid/csr_ready    | csr_wdata capacity_limit
//
// Get passes through a fetch state; clear and failed operations go straight to the
// result. Insert and delete move one entry at a time through the single RAM port
// pair, in a read and a write state each. One request is in flight at a time;
// req_tready is high only while idle. The result holds until rsp_tready.
// Reset is synchronous; it empties the list and sets capacity to 64.
module positional_array_list_unit #(
   parameter int DEPTH      = pal_pkg::DEPTH_DEF,
   parameter int WORD_WIDTH = pal_pkg::WORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pal_pkg::REQ_DATA_W-1:0]  req_tdata,  // position[5:0], value[37:6], zero pad
   input  logic [pal_pkg::OP_W-1:0]        req_tuser,  // operation[1:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pal_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // read_value[31:0], list_length[38:32], pad
   output logic                            rsp_tuser,  // ok[0]
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pal_pkg::CAP_W-1:0]       csr_wdata
);
   import pal_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FETCH = 6'b000010,
      ST_READ  = 6'b000100,
      ST_WRITE = 6'b001000,
      ST_LOAD  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [WORD_WIDTH-1:0] value_ff, value_in;
   logic                  ok_ff, ok_in;
   logic [VALUE_W-1:0]    rd_ff, rd_in;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

   logic                  req_fire;
   op_type                req_op;
   logic [IW-1:0]         pos_x, count_x, cap_x, effcap_x, pos_sel;
   logic [CW-1:0]         idx_m1, idx_p1, pos_p1;
   logic [63:0]           value_wide, rd_wide;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign csr_ready  = 1'b1;

   assign pos_x    = IW'(req_tdata[POS_W-1:0]);
   assign count_x  = IW'(count_ff);
   assign cap_x    = IW'(cap_ff);
   assign effcap_x = (cap_x < IW'(DEPTH)) ? cap_x : IW'(DEPTH);
   assign pos_sel  = (pos_x > count_x) ? count_x : pos_x;

   assign idx_m1 = idx_ff - 1'b1;
   assign idx_p1 = idx_ff + 1'b1;
   assign pos_p1 = pos_ff + 1'b1;

   assign value_wide = 64'(req_tdata[POS_W +: VALUE_W]);
   assign rd_wide    = 64'(ram_rdata);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      count_in  = count_ff;
      cap_in    = cap_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      value_in  = value_ff;
      ok_in     = ok_ff;
      rd_in     = rd_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_raddr = idx_ff[AW-1:0];
      ram_wdata = ram_rdata;

      if (csr_valid && csr_ready) begin
         cap_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_op;
               pos_in   = pos_sel[CW-1:0];
               idx_in   = count_ff;
               value_in = value_wide[WORD_WIDTH-1:0];
               ok_in    = 1'b0;
               rd_in    = '0;
               state_in = ST_RESP;
               case (req_op)
                  OP_INSERT: begin
                     if (count_x < effcap_x) begin
                        state_in = (count_x > pos_sel) ? ST_READ : ST_LOAD;
                     end
                  end
                  OP_GET, OP_DELETE: begin
                     if (pos_x < count_x) begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_sel[AW-1:0];
                        state_in  = ST_FETCH;
                     end
                  end
                  default: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            ok_in = 1'b1;
            rd_in = rd_wide[VALUE_W-1:0];
            if (op_ff == OP_DELETE) begin
               idx_in = pos_p1;
               if (pos_p1 < count_ff) begin
                  state_in = ST_READ;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = ST_RESP;
               end
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            ram_re    = 1'b1;
            ram_raddr = (op_ff == OP_INSERT) ? idx_m1[AW-1:0] : idx_ff[AW-1:0];
            state_in  = ST_WRITE;
         end
         ST_WRITE: begin
            ram_we = 1'b1;
            if (op_ff == OP_INSERT) begin
               ram_waddr = idx_ff[AW-1:0];
               idx_in    = idx_m1;
               state_in  = (idx_m1 > pos_ff) ? ST_READ : ST_LOAD;
            end else begin
               ram_waddr = idx_m1[AW-1:0];
               idx_in    = idx_p1;
               if (idx_p1 < count_ff) begin
                  state_in = ST_READ;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = ST_RESP;
               end
            end
         end
         ST_LOAD: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            ram_wdata = value_ff;
            count_in  = count_ff + 1'b1;
            ok_in     = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cap_ff   <= cap_in;
      end
      op_ff    <= op_in;
      pos_ff   <= pos_in;
      idx_ff   <= idx_in;
      value_ff <= value_in;
      ok_ff    <= ok_in;
      rd_ff    <= rd_in;
   end

   pal_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tuser  = ok_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - VALUE_W - LEN_W){1'b0}}, LEN_W'(count_ff), rd_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      IW'(count_ff) <= IW'(DEPTH))
      else $error("list length exceeds store depth");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (op_ff == OP_CLEAR) |-> ok_ff && (count_ff == '0))
      else $error("clear did not empty the list");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !ok_ff |-> (rd_ff == '0))
      else $error("failed request returned nonzero data");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_WRITE) || (state_ff == ST_LOAD))
      else $error("store written outside a shift or load step");

   a_length_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the list by one");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for positional_array_list_unit: directed and random list requests
// checked against a list shadow or fixed results. Depends on pal_pkg and the unit's RTL.
module testbench;
   import pal_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEF;
   localparam int LONG_HOLD  = 300;

   typedef struct packed {
      logic              ok;
      logic [31:0]       word;
      logic [LEN_W-1:0]  length;
   } list_result_type;

   typedef struct {
      op_type          op;
      logic [5:0]      pos;
      logic [31:0]     word;
      bit              typed;
      list_result_type res;
   } list_row_type;

   typedef struct {
      int cap;
      int items;
      int w_ins;
      int w_get;
      int w_del;
      int w_clr;
      int gap_pct;
      int stall_pct;
      bit hold;
      bit quiet;
   } phase_plan_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [OP_W-1:0]        req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CAP_W-1:0]       csr_wdata = '0;

   positional_array_list_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow list
   logic [31:0] shadow_words [LIST_DEPTH];
   int          shadow_len = 0;
   int          shadow_cap = 64;

   list_result_type expected_q[$];
   int          failures = 0;
   int          src_gap_pct = 0;
   int          sink_stall_pct = 0;
   bit          sink_quiet = 0;
   bit          hold_pending = 0;

   int n_ins_ok = 0, n_ins_full = 0, n_get_ok = 0, n_get_bad = 0;
   int n_del_ok = 0, n_del_bad = 0, n_clear = 0, peak_len = 0, n_results = 0;

   function automatic list_result_type apply_list_op(op_type op, logic [5:0] pos,
                                                     logic [31:0] word);
      list_result_type r;
      int         cap;
      int         p;
      int         i;
      r = '0;
      cap = shadow_cap < LIST_DEPTH ? shadow_cap : LIST_DEPTH;
      case (op)
         OP_INSERT: begin
            if (shadow_len + 1 <= cap) begin
               p = (int'(pos) > shadow_len) ? shadow_len : int'(pos);
               for (i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[p] = word;
               shadow_len++;
               r.ok = 1'b1;
               n_ins_ok++;
            end else begin
               n_ins_full++;
            end
         end
         OP_GET, OP_DELETE: begin
            if (int'(pos) < shadow_len) begin
               r.word = shadow_words[pos];
               r.ok = 1'b1;
               if (op == OP_DELETE) begin
                  for (i = int'(pos) + 1; i < shadow_len; i++)
                     shadow_words[i-1] = shadow_words[i];
                  shadow_len--;
                  n_del_ok++;
               end else begin
                  n_get_ok++;
               end
            end else if (op == OP_DELETE) begin
               n_del_bad++;
            end else begin
               n_get_bad++;
            end
         end
         default: begin
            shadow_len = 0;
            r.ok = 1'b1;
            n_clear++;
         end
      endcase
      r.length = LEN_W'(shadow_len);
      if (shadow_len > peak_len) peak_len = shadow_len;
      return r;
   endfunction

   // one request: hold valid until accepted, then maybe idle a burst
   task automatic send_request(op_type op, logic [5:0] pos, logic [31:0] word, bit typed,
                               list_result_type typed_res);
      list_result_type pred;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, word, pos};
      do @(posedge clock); while (!req_tready);
      pred = apply_list_op(op, pos, word);
      expected_q.push_back(typed ? typed_res : pred);
      if ($urandom_range(0, 99) < src_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(int cap);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= CAP_W'(cap);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_cap = cap;
   endtask

   task automatic pick_request(phase_plan_type pp, output op_type op, output logic [5:0] pos,
                               output logic [31:0] word);
      int roll;
      int hi;
      roll = $urandom_range(0, pp.w_ins + pp.w_get + pp.w_del + pp.w_clr - 1);
      if (roll < pp.w_ins) op = OP_INSERT;
      else if (roll < pp.w_ins + pp.w_get) op = OP_GET;
      else if (roll < pp.w_ins + pp.w_get + pp.w_del) op = OP_DELETE;
      else op = OP_CLEAR;
      hi = shadow_len > 63 ? 63 : shadow_len;
      if ($urandom_range(0, 99) < 70) pos = 6'($urandom_range(0, hi));
      else pos = 6'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
         0:       word = 32'h0000_0000;
         1:       word = 32'hFFFF_FFFF;
         default: word = $urandom;
      endcase
   endtask

   // result checker
   always @(posedge clock) begin
      list_result_type got;
      list_result_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok     = rsp_tuser;
         got.word   = rsp_tdata[31:0];
         got.length = rsp_tdata[38:32];
         n_results++;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: ok=%0b word=%h len=%0d",
                        got.ok, got.word, got.length);
         end else begin
            exp = expected_q.pop_front();
            if (got.ok !== exp.ok || got.word !== exp.word || got.length !== exp.length) begin
               failures++;
               if (failures <= 10)
                  $display({"mismatch on response %0d: exp ok=%0b word=%h len=%0d, ",
                            "got ok=%0b word=%h len=%0d"},
                           n_results, exp.ok, exp.word, exp.length,
                           got.ok, got.word, got.length);
            end
         end
      end
   end

   // response sink: random stalls, one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else if (!sink_quiet && $urandom_range(0, 99) < sink_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #15_000_000;
      $display("timeout with %0d responses outstanding", expected_q.size());
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      list_row_type   directed_rows[20];
      phase_plan_type phases[8];
      op_type      op;
      logic [5:0]  pos;
      logic [31:0] word;

      directed_rows = '{
         '{OP_GET,    6'd0,  32'h0,         1'b1, '{1'b0, 32'h0,         7'd0}},
         '{OP_DELETE, 6'd0,  32'h0,         1'b1, '{1'b0, 32'h0,         7'd0}},
         '{OP_INSERT, 6'd63, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0,         7'd1}},
         '{OP_INSERT, 6'd0,  32'h0000_0000, 1'b1, '{1'b1, 32'h0,         7'd2}},
         '{OP_GET,    6'd0,  32'h0,         1'b1, '{1'b1, 32'h0,         7'd2}},
         '{OP_GET,    6'd1,  32'h0,         1'b1, '{1'b1, 32'hFFFF_FFFF, 7'd2}},
         '{OP_DELETE, 6'd0,  32'h0,         1'b1, '{1'b1, 32'h0,         7'd1}},
         '{OP_GET,    6'd1,  32'h0,         1'b1, '{1'b0, 32'h0,         7'd1}},
         '{OP_INSERT, 6'd1,  32'hA5A5_5A5A, 1'b0, '0},
         '{OP_INSERT, 6'd0,  32'h1234_5678, 1'b0, '0},
         '{OP_INSERT, 6'd2,  32'h8000_0001, 1'b0, '0},
         '{OP_GET,    6'd63, 32'h0,         1'b1, '{1'b0, 32'h0,         7'd4}},
         '{OP_DELETE, 6'd1,  32'hDEAD_BEEF, 1'b0, '0},
         '{OP_GET,    6'd2,  32'h0,         1'b0, '0},
         '{OP_DELETE, 6'd2,  32'h0,         1'b0, '0},
         '{OP_CLEAR,  6'd17, 32'h5555_AAAA, 1'b1, '{1'b1, 32'h0,         7'd0}},
         '{OP_CLEAR,  6'd0,  32'h0,         1'b1, '{1'b1, 32'h0,         7'd0}},
         '{OP_INSERT, 6'd5,  32'h0000_FFFF, 1'b0, '0},
         '{OP_GET,    6'd0,  32'h0,         1'b0, '0},
         '{OP_DELETE, 6'd0,  32'h0,         1'b0, '0}
      };

      // cap, items, insert/get/delete/clear weights, sender gap %, sink stall %, hold, quiet
      phases = '{
         '{64,  290, 550, 200, 200,   5, 20, 20, 1'b1, 1'b0},
         '{3,    80, 300, 300, 380,  20, 10, 10, 1'b0, 1'b0},
         '{0,    40, 500, 200, 200, 100, 25, 25, 1'b0, 1'b0},
         '{127, 150, 600, 150, 240,  10, 30, 30, 1'b0, 1'b0},
         '{1,    60, 400, 250, 250, 100, 20, 20, 1'b0, 1'b0},
         '{2,    60, 400, 250, 250, 100, 15, 15, 1'b0, 1'b0},
         '{42,  130, 500, 200, 280,  20,  0,  0, 1'b0, 1'b0},
         '{64,  120, 450, 250, 280,  20,  0,  0, 1'b0, 1'b1}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      src_gap_pct = 30;
      sink_stall_pct = 30;
      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].word,
                      directed_rows[i].typed, directed_rows[i].res);
      req_tvalid <= 1'b0;

      foreach (phases[k]) begin
         write_capacity(phases[k].cap);
         src_gap_pct = phases[k].gap_pct;
         sink_stall_pct = phases[k].stall_pct;
         sink_quiet = phases[k].quiet;
         for (int n = 0; n < phases[k].items; n++) begin
            if (phases[k].hold && n == 100) hold_pending = 1;
            pick_request(phases[k], op, pos, word);
            send_request(op, pos, word, 1'b0, '0);
         end
         req_tvalid <= 1'b0;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (expected_q.size() != 0) failures += expected_q.size();

      $display("covered %0d responses: insert %0d ok / %0d full, get %0d ok / %0d bad",
               n_results, n_ins_ok, n_ins_full, n_get_ok, n_get_bad);
      $display("delete %0d ok / %0d bad, clear %0d, peak length %0d, %0d failures",
               n_del_ok, n_del_bad, n_clear, peak_len, failures);
      if (failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== positional_array_list_unit.f =====
hw/rtl/pal_pkg.sv
hw/rtl/pal_ram.sv
hw/rtl/positional_array_list_unit.sv
verif/testbench.sv
